/* src/mcpg_pkg.sv */
package mcpg_pkg;

	// field widths
	localparam int BEAT_W     = 48;
	localparam int PPQ_W      = 7;
	localparam int MCU_W      = 5;
	localparam int BYTE_W     = 8;
	localparam int CNT_W      = 5;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = 7;

	localparam int FRACTION_BITS_DEF = 16;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_PPQ = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_MCU = 1'd1;

	localparam logic [PPQ_W-1:0] PPQ_RESET = 7'd24;
	localparam logic [MCU_W-1:0] MCU_RESET = 5'd4;
	localparam logic [MCU_W-1:0] CATCH_UP_CAP = 5'd16;

	// operation codes
	localparam logic OP_POLL     = 1'b0;
	localparam logic OP_SHUTDOWN = 1'b1;

	// real-time bytes
	localparam logic [BYTE_W-1:0] BYTE_CLOCK = 8'hF8;
	localparam logic [BYTE_W-1:0] BYTE_START = 8'hFA;
	localparam logic [BYTE_W-1:0] BYTE_STOP  = 8'hFC;

	typedef struct packed {
		logic load;
		logic mul;
		logic eval;
		logic pop;
	} dp_cmd_t;

	typedef struct packed {
		logic pending;
		logic last;
	} dp_status_t;

endpackage

/* src/mcpg_ifs.sv */
interface mcpg_poll_if;
	logic                           valid;
	logic                           ready;
	logic                           operation;
	logic                           beat_valid;
	logic                           outputs_present;
	logic                           playing;
	logic signed [mcpg_pkg::BEAT_W-1:0] beat_position;

	modport source (output valid, operation, beat_valid, outputs_present, playing,
		beat_position, input ready);
	modport sink (input valid, operation, beat_valid, outputs_present, playing,
		beat_position, output ready);
endinterface

interface mcpg_result_if;
	logic                        valid;
	logic                        ready;
	logic [mcpg_pkg::BYTE_W-1:0] midi_byte;
	logic                        last_of_run;

	modport source (output valid, midi_byte, last_of_run, input ready);
	modport sink (input valid, midi_byte, last_of_run, output ready);
endinterface

interface mcpg_cfg_if;
	logic                            valid;
	logic                            ready;
	logic [mcpg_pkg::CFG_IDX_W-1:0]  index;
	logic [mcpg_pkg::CFG_DATA_W-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/mcpg_dp.sv */
module mcpg_dp #(
	parameter int FRACTION_BITS = mcpg_pkg::FRACTION_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  mcpg_pkg::dp_cmd_t                   cmd,
	output mcpg_pkg::dp_status_t                status,
	input  logic                                operation,
	input  logic                                beat_valid,
	input  logic                                outputs_present,
	input  logic                                playing,
	input  logic signed [mcpg_pkg::BEAT_W-1:0]  beat_position,
	input  logic                                cfg_we,
	input  logic [mcpg_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mcpg_pkg::CFG_DATA_W-1:0]     cfg_data,
	output logic [mcpg_pkg::BYTE_W-1:0]         midi_byte,
	output logic                                last_of_run
);

	localparam int PROD_W  = mcpg_pkg::BEAT_W + mcpg_pkg::PPQ_W + 1;
	localparam int PULSE_W = PROD_W - FRACTION_BITS;
	localparam int CNT_W   = mcpg_pkg::CNT_W;

	// configuration
	logic [mcpg_pkg::PPQ_W-1:0] ppq_q;
	logic [mcpg_pkg::MCU_W-1:0] mcu_q;

	// captured item
	logic                              op_q;
	logic                              bvalid_q;
	logic                              outs_q;
	logic                              play_q;
	logic signed [mcpg_pkg::BEAT_W-1:0] beat_q;
	logic signed [PROD_W-1:0]           prod_q;

	// state and emission queue
	logic                      started_q;
	logic signed [PULSE_W-1:0] last_pulse_q;
	logic                      start_q;
	logic                      stop_q;
	logic [CNT_W-1:0]          clocks_q;

	logic signed [PULSE_W-1:0] pulse;
	logic signed [PULSE_W-1:0] base;
	logic signed [PULSE_W:0]   due;
	logic signed [PULSE_W:0]   limit_wide;
	logic [CNT_W-1:0]          limit;
	logic                      due_pos;
	logic                      due_over;
	logic [CNT_W-1:0]          clocks_new;
	logic [CNT_W:0]            remaining;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ppq_q <= mcpg_pkg::PPQ_RESET;
			mcu_q <= mcpg_pkg::MCU_RESET;
		end else if (cfg_we) begin
			if (cfg_index == mcpg_pkg::REG_PPQ) begin
				ppq_q <= cfg_data;
			end else if (cfg_index == mcpg_pkg::REG_MCU) begin
				mcu_q <= cfg_data[mcpg_pkg::MCU_W-1:0];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q     <= operation;
			bvalid_q <= beat_valid;
			outs_q   <= outputs_present;
			play_q   <= playing;
			beat_q   <= beat_position;
		end
		if (cmd.mul) begin
			prod_q <= PROD_W'(beat_q * $signed({1'b0, ppq_q}));
		end
	end

	// floor division by the fraction scale is an arithmetic shift
	always_comb begin
		pulse      = PULSE_W'(prod_q >>> FRACTION_BITS);
		base       = started_q ? last_pulse_q : pulse;
		due        = (PULSE_W+1)'(pulse) - (PULSE_W+1)'(base);
		limit      = (mcu_q > mcpg_pkg::CATCH_UP_CAP) ? mcpg_pkg::CATCH_UP_CAP : mcu_q;
		limit_wide = (PULSE_W+1)'(limit);
		due_pos    = !due[PULSE_W] && (due != '0);
		due_over   = due > limit_wide;
		if (due_over) begin
			clocks_new = limit;
		end else if (due_pos) begin
			clocks_new = due[CNT_W-1:0];
		end else begin
			clocks_new = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q    <= 1'b0;
			last_pulse_q <= '0;
			start_q      <= 1'b0;
			stop_q       <= 1'b0;
			clocks_q     <= '0;
		end else if (cmd.eval) begin
			if (op_q == mcpg_pkg::OP_SHUTDOWN) begin
				stop_q       <= started_q && outs_q;
				started_q    <= 1'b0;
				last_pulse_q <= '0;
			end else if (bvalid_q && outs_q) begin
				if (!play_q) begin
					stop_q    <= started_q;
					started_q <= 1'b0;
				end else begin
					start_q      <= !started_q;
					started_q    <= 1'b1;
					clocks_q     <= clocks_new;
					last_pulse_q <= due_pos ? pulse : base;
				end
			end
		end else if (cmd.pop) begin
			if (start_q) begin
				start_q <= 1'b0;
			end else if (clocks_q != '0) begin
				clocks_q <= clocks_q - 1'b1;
			end else begin
				stop_q <= 1'b0;
			end
		end
	end

	assign remaining = (CNT_W+1)'(clocks_q) + (CNT_W+1)'(start_q) + (CNT_W+1)'(stop_q);

	always_comb begin
		if (start_q) begin
			midi_byte = mcpg_pkg::BYTE_START;
		end else if (clocks_q != '0) begin
			midi_byte = mcpg_pkg::BYTE_CLOCK;
		end else begin
			midi_byte = mcpg_pkg::BYTE_STOP;
		end
	end

	assign last_of_run    = remaining == (CNT_W+1)'(1);
	assign status.pending = remaining != '0;
	assign status.last    = last_of_run;

endmodule

/* src/mcpg_ctrl.sv */
module mcpg_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	output logic                 out_valid,
	input  logic                 out_ready,
	input  mcpg_pkg::dp_status_t status,
	output mcpg_pkg::dp_cmd_t    cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_EVAL = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_d;

	assign in_ready  = state_q == S_IDLE;
	assign out_valid = (state_q == S_EMIT) && status.pending;

	assign cmd.load = in_valid && in_ready;
	assign cmd.mul  = state_q == S_MUL;
	assign cmd.eval = state_q == S_EVAL;
	assign cmd.pop  = out_valid && out_ready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid) state_d = S_MUL;
			end
			S_MUL:  state_d = S_EVAL;
			S_EVAL: state_d = S_EMIT;
			S_EMIT: begin
				// nothing to send, or last byte taken
				if (!status.pending || (out_ready && status.last)) state_d = S_IDLE;
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* src/midi_clock_pulse_generator.sv */
// MIDI beat clock generator: each poll beat carries a signed fixed-point beat
// position (FRACTION_BITS fraction bits) plus valid, outputs-present and playing
// flags; a shutdown beat ends the session. The block answers with real-time
// bytes phase-locked to the beat: Start (0xFA) on a new play, one Clock (0xF8)
// per whole pulse gained (pulse = floor(beat * pulses_per_quarter)), at most
// max_catch_up (capped at 16) per item, and Stop (0xFC) when transport stops or
// on shutdown after a start. The final byte of an item has last_of_run set.
// Sequence: an item is captured in the idle state, the pulse product is formed in
// the multiply state and the decision in the evaluate state, then the result bytes
// leave one per cycle while the result side is ready; no new item is accepted
// until the last byte of the current item has been taken. Config
// registers (index 0 pulses_per_quarter, index 1 max_catch_up) are always ready.
module midi_clock_pulse_generator #(
	parameter int FRACTION_BITS = mcpg_pkg::FRACTION_BITS_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	mcpg_poll_if.sink     poll,
	mcpg_result_if.source result,
	mcpg_cfg_if.sink      cfg
);

	mcpg_pkg::dp_cmd_t    cmd;
	mcpg_pkg::dp_status_t status;

	// config writes never stall
	assign cfg.ready = 1'b1;

	// sequencer: idle, multiply, decide, emit
	mcpg_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (poll.valid),
		.in_ready  (poll.ready),
		.out_valid (result.valid),
		.out_ready (result.ready),
		.status    (status),
		.cmd       (cmd)
	);

	// pulse arithmetic, session state and the byte queue
	mcpg_dp #(
		.FRACTION_BITS (FRACTION_BITS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.status          (status),
		.operation       (poll.operation),
		.beat_valid      (poll.beat_valid),
		.outputs_present (poll.outputs_present),
		.playing         (poll.playing),
		.beat_position   (poll.beat_position),
		.cfg_we          (cfg.valid && cfg.ready),
		.cfg_index       (cfg.index),
		.cfg_data        (cfg.data),
		.midi_byte       (result.midi_byte),
		.last_of_run     (result.last_of_run)
	);

endmodule

/* src/mcpg_checker.sv */
module mcpg_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        poll_valid,
	input logic                        poll_ready,
	input logic                        res_valid,
	input logic                        res_ready,
	input logic [mcpg_pkg::BYTE_W-1:0] res_byte
);

	// stalled byte holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(res_byte))
		else $error("result byte changed while stalled");

	// only the three real-time codes leave the block
	a_code: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> (res_byte == mcpg_pkg::BYTE_CLOCK || res_byte == mcpg_pkg::BYTE_START
			|| res_byte == mcpg_pkg::BYTE_STOP))
		else $error("unknown real-time byte");

	// one item at a time: no intake while bytes go out
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !poll_ready)
		else $error("intake open during emission");

	// an accepted item closes intake for its processing
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		poll_valid && poll_ready |=> !poll_ready ##1 !poll_ready)
		else $error("intake reopened too early");

endmodule

bind midi_clock_pulse_generator mcpg_checker u_chk (
	.clk        (clk),
	.arst_n     (arst_n),
	.poll_valid (poll.valid),
	.poll_ready (poll.ready),
	.res_valid  (result.valid),
	.res_ready  (result.ready),
	.res_byte   (result.midi_byte)
);
